FILE: design/vvtm_pkg.sv
package vvtm_pkg;

    localparam int VALUE_W    = 64;
    localparam int OP_W       = 3;
    localparam int NODE_W     = 3;
    localparam int APP_W      = 5;
    localparam int TYPE_W     = 2;

    localparam int NODE_CNT_W = 4;
    localparam int APP_CNT_W  = 6;
    localparam int TYPE_CNT_W = 3;
    localparam int OWN_W      = 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE     = 3'd0,
        OP_WRITE_OWN = 3'd1,
        OP_READ      = 3'd2,
        OP_CHECK     = 3'd3,
        OP_MERGE     = 3'd4,
        OP_CLEAR     = 3'd5
    } op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_APP_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_NODE   = 3'd3;

    localparam logic [NODE_CNT_W-1:0] NODE_COUNT_RST = 4'd5;
    localparam logic [APP_CNT_W-1:0]  APP_COUNT_RST  = 6'd20;
    localparam logic [TYPE_CNT_W-1:0] TYPE_COUNT_RST = 3'd2;
    localparam logic [OWN_W-1:0]      OWN_NODE_RST   = 3'd0;

    typedef struct packed {
        logic [NODE_CNT_W-1:0] node_count;
        logic [APP_CNT_W-1:0]  app_count;
        logic [TYPE_CNT_W-1:0] type_count;
        logic [OWN_W-1:0]      own_node;
    } cfg_t;

endpackage

FILE: design/vvtm_store.sv
module vvtm_store #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [vvtm_pkg::VALUE_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]            rd_addr_a,
    input  logic [ADDR_W-1:0]            rd_addr_b,
    output logic [vvtm_pkg::VALUE_W-1:0] rd_data_a,
    output logic [vvtm_pkg::VALUE_W-1:0] rd_data_b
);
    import vvtm_pkg::*;

    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rd_a_reg;
    logic [VALUE_W-1:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

FILE: design/vvtm_cmp.sv
module vvtm_cmp (
    input  logic signed [vvtm_pkg::VALUE_W-1:0] lhs,
    input  logic signed [vvtm_pkg::VALUE_W-1:0] rhs,
    output logic                                lt
);
    import vvtm_pkg::*;

    // signed (two's complement) compare, own entry against peer entry
    assign lt = (lhs < rhs);

endmodule

FILE: design/vvtm_ctrl.sv
module vvtm_ctrl #(
    parameter int MAX_NODES = 8,
    parameter int MAX_APPS  = 32,
    parameter int MAX_TYPES = 4,
    parameter int ADDR_W    = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  vvtm_pkg::cfg_t                      cfg,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [vvtm_pkg::OP_W-1:0]           s_op,
    input  logic [vvtm_pkg::NODE_W-1:0]         s_node_index,
    input  logic [vvtm_pkg::APP_W-1:0]          s_app_index,
    input  logic [vvtm_pkg::TYPE_W-1:0]         s_type_index,
    input  logic signed [vvtm_pkg::VALUE_W-1:0] s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [vvtm_pkg::VALUE_W-1:0] m_read_value,
    output logic                                m_peer_ahead,
    output logic                                m_status,
    output logic                                mem_wr_en,
    output logic [ADDR_W-1:0]                   mem_wr_addr,
    output logic [vvtm_pkg::VALUE_W-1:0]        mem_wr_data,
    output logic [ADDR_W-1:0]                   mem_rd_addr_a,
    output logic [ADDR_W-1:0]                   mem_rd_addr_b,
    input  logic [vvtm_pkg::VALUE_W-1:0]        mem_rd_data_b,
    input  logic [vvtm_pkg::VALUE_W-1:0]        mem_rd_data_a,
    input  logic                                cmp_lt
);
    import vvtm_pkg::*;

    localparam int DEPTH = MAX_NODES * MAX_APPS * MAX_TYPES;
    localparam int NC_W  = $clog2(MAX_NODES + 1);
    localparam int AC_W  = $clog2(MAX_APPS + 1);
    localparam int TC_W  = $clog2(MAX_TYPES + 1);
    localparam int AI_W  = (MAX_APPS > 1) ? $clog2(MAX_APPS) : 1;
    localparam int TI_W  = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_RDWAIT,
        ST_WALK,
        ST_FINISH
    } state_t;

    function automatic logic [ADDR_W-1:0] entry_addr(
        input logic [31:0] n,
        input logic [31:0] a,
        input logic [31:0] t
    );
        entry_addr = ADDR_W'((n * MAX_APPS + a) * MAX_TYPES + t);
    endfunction

    state_t              state_reg, state_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [NODE_W-1:0]   ni_reg, ni_next;
    logic [APP_W-1:0]    ai_reg, ai_next;
    logic [TYPE_W-1:0]   ti_reg, ti_next;
    logic [VALUE_W-1:0]  val_reg, val_next;
    logic [AI_W-1:0]     a_cnt_reg, a_cnt_next;
    logic [TI_W-1:0]     t_cnt_reg, t_cnt_next;
    logic                iss_done_reg, iss_done_next;
    logic                p_vld_reg, p_vld_next;
    logic [ADDR_W-1:0]   p_addr_reg, p_addr_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic                clr_reply_reg, clr_reply_next;
    logic                ahead_reg, ahead_next;
    logic                status_reg, status_next;
    logic [VALUE_W-1:0]  rdv_reg, rdv_next;
    logic                m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0]  m_rdv_reg, m_rdv_next;
    logic                m_ahead_reg, m_ahead_next;
    logic                m_status_reg, m_status_next;

    logic [NC_W-1:0]     nc;
    logic [AC_W-1:0]     ac;
    logic [TC_W-1:0]     tc;
    logic [NODE_W-1:0]   node_sel;
    logic                entry_err;
    logic                peer_err;
    logic                t_last;
    logic                a_last;
    logic [ADDR_W-1:0]   own_walk_addr;
    logic [ADDR_W-1:0]   peer_walk_addr;

    // counts above the maximum act as the maximum
    assign nc = (32'(cfg.node_count) > 32'(MAX_NODES)) ? NC_W'(MAX_NODES) : NC_W'(cfg.node_count);
    assign ac = (32'(cfg.app_count) > 32'(MAX_APPS))   ? AC_W'(MAX_APPS)  : AC_W'(cfg.app_count);
    assign tc = (32'(cfg.type_count) > 32'(MAX_TYPES)) ? TC_W'(MAX_TYPES) : TC_W'(cfg.type_count);

    assign node_sel  = (op_t'(op_reg) == OP_WRITE_OWN) ? NODE_W'(cfg.own_node) : ni_reg;
    assign entry_err = (32'(node_sel) >= 32'(nc)) || (32'(ai_reg) >= 32'(ac))
                       || (32'(ti_reg) >= 32'(tc));
    assign peer_err  = (32'(ni_reg) >= 32'(nc)) || (32'(cfg.own_node) >= 32'(nc));

    assign t_last = (32'(t_cnt_reg) + 32'd1 >= 32'(tc));
    assign a_last = (32'(a_cnt_reg) + 32'd1 >= 32'(ac));

    assign own_walk_addr  = entry_addr(32'(cfg.own_node), 32'(a_cnt_reg), 32'(t_cnt_reg));
    assign peer_walk_addr = entry_addr(32'(ni_reg), 32'(a_cnt_reg), 32'(t_cnt_reg));

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        ni_next        = ni_reg;
        ai_next        = ai_reg;
        ti_next        = ti_reg;
        val_next       = val_reg;
        a_cnt_next     = a_cnt_reg;
        t_cnt_next     = t_cnt_reg;
        iss_done_next  = iss_done_reg;
        p_vld_next     = p_vld_reg;
        p_addr_next    = p_addr_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_reply_next = clr_reply_reg;
        ahead_next     = ahead_reg;
        status_next    = status_reg;
        rdv_next       = rdv_reg;
        m_valid_next   = m_valid_reg;
        m_rdv_next     = m_rdv_reg;
        m_ahead_next   = m_ahead_reg;
        m_status_next  = m_status_reg;

        mem_wr_en     = 1'b0;
        mem_wr_addr   = p_addr_reg;
        mem_wr_data   = mem_rd_data_b;
        mem_rd_addr_a = own_walk_addr;
        mem_rd_addr_b = peer_walk_addr;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                mem_wr_en    = 1'b1;
                mem_wr_addr  = clr_cnt_reg;
                mem_wr_data  = '0;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1)) begin
                    clr_cnt_next = '0;
                    state_next   = clr_reply_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    op_next     = s_op;
                    ni_next     = s_node_index;
                    ai_next     = s_app_index;
                    ti_next     = s_type_index;
                    val_next    = s_value;
                    ahead_next  = 1'b0;
                    status_next = 1'b0;
                    rdv_next    = '0;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_FINISH;
                case (op_t'(op_reg))
                    OP_WRITE, OP_WRITE_OWN: begin
                        if (entry_err) begin
                            status_next = 1'b1;
                        end else begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = entry_addr(32'(node_sel), 32'(ai_reg), 32'(ti_reg));
                            mem_wr_data = val_reg;
                        end
                    end
                    OP_READ: begin
                        if (entry_err) begin
                            status_next = 1'b1;
                        end else begin
                            mem_rd_addr_a = entry_addr(32'(ni_reg), 32'(ai_reg), 32'(ti_reg));
                            state_next    = ST_RDWAIT;
                        end
                    end
                    OP_CHECK, OP_MERGE: begin
                        if (peer_err) begin
                            status_next = 1'b1;
                        end else if ((ni_reg != NODE_W'(cfg.own_node)) && (ac != '0)
                                     && (tc != '0)) begin
                            a_cnt_next    = '0;
                            t_cnt_next    = '0;
                            iss_done_next = 1'b0;
                            p_vld_next    = 1'b0;
                            state_next    = ST_WALK;
                        end
                    end
                    OP_CLEAR: begin
                        clr_cnt_next   = '0;
                        clr_reply_next = 1'b1;
                        state_next     = ST_CLEAR;
                    end
                    default: begin
                    end
                endcase
            end
            ST_RDWAIT: begin
                rdv_next   = mem_rd_data_a;
                state_next = ST_FINISH;
            end
            ST_WALK: begin
                // issue reads for the next pair while comparing the last one
                p_vld_next = 1'b0;
                if (!iss_done_reg) begin
                    p_vld_next  = 1'b1;
                    p_addr_next = own_walk_addr;
                    if (t_last) begin
                        t_cnt_next = '0;
                        a_cnt_next = a_cnt_reg + AI_W'(1);
                        if (a_last) begin
                            iss_done_next = 1'b1;
                        end
                    end else begin
                        t_cnt_next = t_cnt_reg + TI_W'(1);
                    end
                end
                if (p_vld_reg && cmp_lt) begin
                    if (op_t'(op_reg) == OP_CHECK) begin
                        ahead_next = 1'b1;
                    end else begin
                        mem_wr_en = 1'b1;
                    end
                end
                if (iss_done_reg) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_rdv_next     = rdv_reg;
                    m_ahead_next   = ahead_reg;
                    m_status_next  = status_reg;
                    clr_reply_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            clr_reply_reg <= 1'b0;
            iss_done_reg  <= 1'b0;
            p_vld_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_reply_reg <= clr_reply_next;
            iss_done_reg  <= iss_done_next;
            p_vld_reg     <= p_vld_next;
            m_valid_reg   <= m_valid_next;
        end
        op_reg       <= op_next;
        ni_reg       <= ni_next;
        ai_reg       <= ai_next;
        ti_reg       <= ti_next;
        val_reg      <= val_next;
        a_cnt_reg    <= a_cnt_next;
        t_cnt_reg    <= t_cnt_next;
        p_addr_reg   <= p_addr_next;
        ahead_reg    <= ahead_next;
        status_reg   <= status_next;
        rdv_reg      <= rdv_next;
        m_rdv_reg    <= m_rdv_next;
        m_ahead_reg  <= m_ahead_next;
        m_status_reg <= m_status_next;
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_read_value = m_rdv_reg;
    assign m_peer_ahead = m_ahead_reg;
    assign m_status     = m_status_reg;

endmodule

FILE: design/version_vector_table_merge.sv
// Steps from accepted beat to result: write EXEC, FINISH; read EXEC, RDWAIT, FINISH;
// check/merge EXEC, walk of app_count*type_count pairs (none on error or own row), FINISH;
// clear EXEC, sweep of the DEPTH entries, FINISH. One entry pair per cycle through the
// two-read-port store and the shared comparator. One beat in flight; s_ready returns as the
// result register is loaded. Reset (aresetn low, synchronous) restores the control and config
// registers and then sweeps the store to zero, during which s_ready stays low.
module version_vector_table_merge #(
    parameter int MAX_NODES = 8,
    parameter int MAX_APPS  = 32,
    parameter int MAX_TYPES = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // register writes
    input  logic                                cfg_we,
    input  logic [vvtm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vvtm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // operation beats
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [vvtm_pkg::OP_W-1:0]           s_op,
    input  logic [vvtm_pkg::NODE_W-1:0]         s_node_index,
    input  logic [vvtm_pkg::APP_W-1:0]          s_app_index,
    input  logic [vvtm_pkg::TYPE_W-1:0]         s_type_index,
    input  logic signed [vvtm_pkg::VALUE_W-1:0] s_value,
    // result beats
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [vvtm_pkg::VALUE_W-1:0] m_read_value,
    output logic                                m_peer_ahead,
    output logic                                m_status
);
    import vvtm_pkg::*;

    // one entry per (node, application, type), rows laid out node-major
    localparam int DEPTH  = MAX_NODES * MAX_APPS * MAX_TYPES;
    localparam int ADDR_W = $clog2(DEPTH);

    cfg_t cfg_reg, cfg_next;

    logic                mem_wr_en;
    logic [ADDR_W-1:0]   mem_wr_addr;
    logic [VALUE_W-1:0]  mem_wr_data;
    logic [ADDR_W-1:0]   mem_rd_addr_a;
    logic [ADDR_W-1:0]   mem_rd_addr_b;
    logic [VALUE_W-1:0]  mem_rd_data_a;
    logic [VALUE_W-1:0]  mem_rd_data_b;
    logic                cmp_lt;

    // Register file. Writes to an index past the list are dropped; only the
    // low bits of the write data that the register holds are kept.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_NODE_COUNT: cfg_next.node_count = cfg_wdata[NODE_CNT_W-1:0];
                CFG_APP_COUNT:  cfg_next.app_count  = cfg_wdata[APP_CNT_W-1:0];
                CFG_TYPE_COUNT: cfg_next.type_count = cfg_wdata[TYPE_CNT_W-1:0];
                CFG_OWN_NODE:   cfg_next.own_node   = cfg_wdata[OWN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.node_count <= NODE_COUNT_RST;
            cfg_reg.app_count  <= APP_COUNT_RST;
            cfg_reg.type_count <= TYPE_COUNT_RST;
            cfg_reg.own_node   <= OWN_NODE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Sequencer: decodes the beat, runs the row walk and the clearing sweep,
    // and holds the result register so a new beat can come in behind it.
    vvtm_ctrl #(
        .MAX_NODES (MAX_NODES),
        .MAX_APPS  (MAX_APPS),
        .MAX_TYPES (MAX_TYPES),
        .ADDR_W    (ADDR_W)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_node_index  (s_node_index),
        .s_app_index   (s_app_index),
        .s_type_index  (s_type_index),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_value  (m_read_value),
        .m_peer_ahead  (m_peer_ahead),
        .m_status      (m_status),
        .mem_wr_en     (mem_wr_en),
        .mem_wr_addr   (mem_wr_addr),
        .mem_wr_data   (mem_wr_data),
        .mem_rd_addr_a (mem_rd_addr_a),
        .mem_rd_addr_b (mem_rd_addr_b),
        .mem_rd_data_b (mem_rd_data_b),
        .mem_rd_data_a (mem_rd_data_a),
        .cmp_lt        (cmp_lt)
    );

    // Timestamp store: in the row walk port A reads the own row, port B the peer row.
    // Merge writes the peer value back over the own entry in the cycle after the reads are issued.
    vvtm_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk      (aclk),
        .wr_en     (mem_wr_en),
        .wr_addr   (mem_wr_addr),
        .wr_data   (mem_wr_data),
        .rd_addr_a (mem_rd_addr_a),
        .rd_addr_b (mem_rd_addr_b),
        .rd_data_a (mem_rd_data_a),
        .rd_data_b (mem_rd_data_b)
    );

    // Shared signed comparator: own entry below peer entry means peer ahead.
    vvtm_cmp u_cmp (
        .lhs (mem_rd_data_a),
        .rhs (mem_rd_data_b),
        .lt  (cmp_lt)
    );

endmodule

FILE: design/vvtm_checker.sv
module vvtm_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [vvtm_pkg::VALUE_W-1:0] m_read_value,
    input logic                                m_peer_ahead,
    input logic                                m_status
);

    // reset empties the result register and holds off new beats
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("result or ready seen straight after reset");

    // one beat at a time: ready drops after every accepted beat
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second beat accepted while one is in progress");

    // an error result carries nothing else
    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_read_value == '0 && !m_peer_ahead)
        else $error("error result with data");

    // a peer-ahead result never carries read data or an error
    a_ahead_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_peer_ahead |-> m_read_value == '0 && !m_status)
        else $error("peer ahead flag mixed with other fields");

    // a stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_value)
            && $stable(m_peer_ahead) && $stable(m_status))
        else $error("stalled result changed");

endmodule

bind version_vector_table_merge vvtm_checker u_vvtm_checker (.*);
